[rtl/ep2t_pkg.sv]
// ----------------------------------------------------------------------------
// ep2t_pkg
// Shared types and constants for the pose-to-transform pipeline.
// ----------------------------------------------------------------------------
package ep2t_pkg;

	localparam int XW = 34;
	localparam int ZW = 33;
	localparam int TW = 32;
	localparam int AW = 16;
	localparam int QW = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	typedef struct packed {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 flip;
	} lane_t;

	typedef struct packed {
		lane_t [2:0]           lane;
		logic  [2:0][TW-1:0]   trans;
	} cordic_t;

	function automatic logic [31:0] atan_entry(input int idx);
		logic [31:0] r;
		case (idx)
			0:  r = 32'd536870912;
			1:  r = 32'd316933406;
			2:  r = 32'd167458907;
			3:  r = 32'd85004756;
			4:  r = 32'd42667331;
			5:  r = 32'd21354465;
			6:  r = 32'd10680862;
			7:  r = 32'd5340757;
			8:  r = 32'd2670675;
			9:  r = 32'd1335343;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/ep2t_cordic_cell.sv]
// ----------------------------------------------------------------------------
// ep2t_cordic_cell
// One CORDIC micro-rotation for all three angles, with its own pipeline slot.
// ----------------------------------------------------------------------------
module ep2t_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ep2t_pkg::cordic_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output ep2t_pkg::cordic_t out_data
);
	import ep2t_pkg::*;

	localparam logic signed [ZW-1:0] ATAN = ZW'(atan_entry(SHIFT));

	logic    valid_q;
	cordic_t data_q;
	cordic_t next_data;

	always_comb begin
		next_data = in_data;
		for (int k = 0; k < 3; k++) begin
			if (!in_data.lane[k].z[ZW-1]) begin
				next_data.lane[k].x = in_data.lane[k].x - (in_data.lane[k].y >>> SHIFT);
				next_data.lane[k].y = in_data.lane[k].y + (in_data.lane[k].x >>> SHIFT);
				next_data.lane[k].z = in_data.lane[k].z - ATAN;
			end else begin
				next_data.lane[k].x = in_data.lane[k].x + (in_data.lane[k].y >>> SHIFT);
				next_data.lane[k].y = in_data.lane[k].y - (in_data.lane[k].x >>> SHIFT);
				next_data.lane[k].z = in_data.lane[k].z + ATAN;
			end
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= next_data;
		end
	end

endmodule

[rtl/ep2t_matrix_unit.sv]
// ----------------------------------------------------------------------------
// ep2t_matrix_unit
// Rounds the CORDIC results to Q2.14 and forms the nine rotation entries.
// ----------------------------------------------------------------------------
module ep2t_matrix_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  ep2t_pkg::cordic_t          in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [ep2t_pkg::QW-1:0] r_out [9],
	output logic [2:0][ep2t_pkg::TW-1:0]   trans_out
);
	import ep2t_pkg::*;

	localparam int SW = 48;

	function automatic logic signed [16:0] to_q14(input logic signed [XW-1:0] v, input logic flip);
		logic signed [XW:0]   t;
		logic signed [XW-16:0] sh;
		logic signed [16:0]   s;
		t  = (XW+1)'(v) + (XW+1)'(32768);
		sh = (XW-15)'(t >>> 16);
		if (sh > 16384) s = 17'sd16384;
		else if (sh < -16384) s = -17'sd16384;
		else s = 17'(sh);
		return flip ? -s : s;
	endfunction

	function automatic logic signed [QW-1:0] round42(input logic signed [SW-1:0] v);
		logic signed [SW-1:0]    t;
		logic signed [SW-29:0]   sh;
		logic signed [QW-1:0]    r;
		t  = v + SW'(1 << 27);
		sh = (SW-28)'(t >>> 28);
		if (sh > 16384) r = 16'sd16384;
		else if (sh < -16384) r = -16'sd16384;
		else r = QW'(sh);
		return r;
	endfunction

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [16:0] sr_s1, cr_s1, sp_s1, cp_s1, sy_s1, cy_s1;
	logic [2:0][TW-1:0] tr_s1, tr_s2, tr_s3, tr_s4;

	logic signed [33:0] cycp_s2, sycp_s2, cpsr_s2, cpcr_s2, cysp_s2, sysp_s2;
	logic signed [33:0] sycr_s2, sysr_s2, cycr_s2, cysr_s2;
	logic signed [16:0] sr_s2, cr_s2, sp_s2;

	logic signed [SW-1:0] e_s3 [9];
	logic signed [QW-1:0] r_s4 [9];

	assign rdy4     = !v4_s4 || out_ready;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			sr_s1 <= to_q14(in_data.lane[0].y, in_data.lane[0].flip);
			cr_s1 <= to_q14(in_data.lane[0].x, in_data.lane[0].flip);
			sp_s1 <= to_q14(in_data.lane[1].y, in_data.lane[1].flip);
			cp_s1 <= to_q14(in_data.lane[1].x, in_data.lane[1].flip);
			sy_s1 <= to_q14(in_data.lane[2].y, in_data.lane[2].flip);
			cy_s1 <= to_q14(in_data.lane[2].x, in_data.lane[2].flip);
			tr_s1 <= in_data.trans;
		end
		if (rdy2 && v1_s1) begin
			cycp_s2 <= 34'(cy_s1) * 34'(cp_s1);
			sycp_s2 <= 34'(sy_s1) * 34'(cp_s1);
			cpsr_s2 <= 34'(cp_s1) * 34'(sr_s1);
			cpcr_s2 <= 34'(cp_s1) * 34'(cr_s1);
			cysp_s2 <= 34'(cy_s1) * 34'(sp_s1);
			sysp_s2 <= 34'(sy_s1) * 34'(sp_s1);
			sycr_s2 <= 34'(sy_s1) * 34'(cr_s1);
			sysr_s2 <= 34'(sy_s1) * 34'(sr_s1);
			cycr_s2 <= 34'(cy_s1) * 34'(cr_s1);
			cysr_s2 <= 34'(cy_s1) * 34'(sr_s1);
			sr_s2   <= sr_s1;
			cr_s2   <= cr_s1;
			sp_s2   <= sp_s1;
			tr_s2   <= tr_s1;
		end
		if (rdy3 && v2_s2) begin
			e_s3[0] <= SW'(cycp_s2) <<< 14;
			e_s3[1] <= SW'(cysp_s2) * SW'(sr_s2) - (SW'(sycr_s2) <<< 14);
			e_s3[2] <= SW'(cysp_s2) * SW'(cr_s2) + (SW'(sysr_s2) <<< 14);
			e_s3[3] <= SW'(sycp_s2) <<< 14;
			e_s3[4] <= SW'(sysp_s2) * SW'(sr_s2) + (SW'(cycr_s2) <<< 14);
			e_s3[5] <= SW'(sysp_s2) * SW'(cr_s2) - (SW'(cysr_s2) <<< 14);
			e_s3[6] <= -(SW'(sp_s2) <<< 28);
			e_s3[7] <= SW'(cpsr_s2) <<< 14;
			e_s3[8] <= SW'(cpcr_s2) <<< 14;
			tr_s3   <= tr_s2;
		end
		if (rdy4 && v3_s3) begin
			for (int k = 0; k < 9; k++) begin
				r_s4[k] <= round42(e_s3[k]);
			end
			tr_s4 <= tr_s3;
		end
	end

	assign out_valid = v4_s4;
	assign r_out     = r_s4;
	assign trans_out = tr_s4;

endmodule

[rtl/euler_pose_to_transform_unit.sv]
// ----------------------------------------------------------------------------
// euler_pose_to_transform_unit
// Pose to rigid transform: R = Rz(yaw) * Ry(pitch) * Rx(roll) plus translation.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready) carries one pose per transfer: three
// Q16.16 translations and roll, pitch and yaw in binary radians. The output
// channel (out_valid, out_ready) carries the nine Q2.14 matrix entries and the
// translation, unchanged. A pose enters a chain of CORDIC_STAGES cells, capped
// at ATAN_ENTRIES, each doing one micro-rotation for all three angles, then
// four stages that round, multiply, sum and saturate. Throughput is one pose
// per cycle while out_ready holds high. Every stage has its own valid bit
// and advances when the next stage is empty or moving, so bubbles close up
// and the unit keeps taking poses while a result waits on a stalled receiver
// until the whole chain is full.
// Reset clears all valid bits; no result is presented until a pose arrives.
// ----------------------------------------------------------------------------
module euler_pose_to_transform_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] trans_x,
	input  logic signed [31:0] trans_y,
	input  logic signed [31:0] trans_z,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic signed [15:0] yaw_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] r00,
	output logic signed [15:0] r01,
	output logic signed [15:0] r02,
	output logic signed [15:0] r10,
	output logic signed [15:0] r11,
	output logic signed [15:0] r12,
	output logic signed [15:0] r20,
	output logic signed [15:0] r21,
	output logic signed [15:0] r22,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z
);
	import ep2t_pkg::*;

	localparam int NC = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

	function automatic lane_t start_lane(input logic signed [AW-1:0] a);
		lane_t l;
		logic signed [AW:0] f;
		f = (AW+1)'(a);
		l.flip = 1'b0;
		if (f > 17'sd16384) begin
			f = f - 17'sd32768;
			l.flip = 1'b1;
		end else if (f < -17'sd16384) begin
			f = f + 17'sd32768;
			l.flip = 1'b1;
		end
		l.x = CORDIC_GAIN_Q30;
		l.y = '0;
		l.z = {f, 16'b0};
		return l;
	endfunction

	cordic_t head_data;
	cordic_t chain_data  [NC+1];
	logic    chain_valid [NC+1];
	logic    chain_ready [NC+1];
	logic signed [QW-1:0] r_all [9];
	logic [2:0][TW-1:0]   trans_all;

	always_comb begin
		head_data.lane[0]  = start_lane(roll_angle);
		head_data.lane[1]  = start_lane(pitch_angle);
		head_data.lane[2]  = start_lane(yaw_angle);
		head_data.trans[0] = trans_x;
		head_data.trans[1] = trans_y;
		head_data.trans[2] = trans_z;
	end

	assign chain_data[0]  = head_data;
	assign chain_valid[0] = in_valid;
	assign in_ready       = chain_ready[0];

	for (genvar i = 0; i < NC; i++) begin : g_cell
		ep2t_cordic_cell #(
			.SHIFT(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_valid[i]),
			.in_ready (chain_ready[i]),
			.in_data  (chain_data[i]),
			.out_valid(chain_valid[i+1]),
			.out_ready(chain_ready[i+1]),
			.out_data (chain_data[i+1])
		);
	end

	ep2t_matrix_unit u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chain_valid[NC]),
		.in_ready (chain_ready[NC]),
		.in_data  (chain_data[NC]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.r_out    (r_all),
		.trans_out(trans_all)
	);

	assign r00   = r_all[0];
	assign r01   = r_all[1];
	assign r02   = r_all[2];
	assign r10   = r_all[3];
	assign r11   = r_all[4];
	assign r12   = r_all[5];
	assign r20   = r_all[6];
	assign r21   = r_all[7];
	assign r22   = r_all[8];
	assign out_x = trans_all[0];
	assign out_y = trans_all[1];
	assign out_z = trans_all[2];

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output stage is empty");

	a_r00_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (r00 <= 16'sd16384 && r00 >= -16'sd16384))
		else $error("r00 outside the saturation range");

	a_r20_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (r20 <= 16'sd16384 && r20 >= -16'sd16384))
		else $error("r20 outside the saturation range");

	a_r22_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (r22 <= 16'sd16384 && r22 >= -16'sd16384))
		else $error("r22 outside the saturation range");

endmodule

[tb/euler_pose_to_transform_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_pose_to_transform_unit_tb
// Checks the pose-to-transform pipeline against an in-bench predictor.
// ----------------------------------------------------------------------------
// Poses go in through a randomly idling sender. Transforms come out to a
// receiver that stalls at random. Each pose's rotation matrix is computed with
// a CORDIC and fixed-point model in the bench. The expected transforms are
// queued, and every transform that leaves the block is compared field by
// field with the oldest one.
// ----------------------------------------------------------------------------
module euler_pose_to_transform_unit_tb;

	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 4;
	localparam longint CYCLE_LIMIT = 400000;
	localparam longint ONE_Q14 = 16384;

	typedef struct {
		logic signed [31:0] tx, ty, tz;
		logic signed [15:0] roll, pitch, yaw;
	} pose_t;

	typedef struct {
		logic signed [15:0] r [9];
		logic signed [31:0] tx, ty, tz;
	} xform_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [31:0] trans_x, trans_y, trans_z;
	logic signed [15:0] roll_angle, pitch_angle, yaw_angle;
	logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic signed [31:0] out_x, out_y, out_z;

	pose_t pending_poses [$];
	xform_t expected_xforms [$];
	int errors = 0;
	int poses_sent = 0;
	int xforms_seen = 0;
	longint cycles = 0;
	bit hold_sender = 0;
	int send_gap = 0;
	int recv_gap = 0;

	euler_pose_to_transform_unit #(.CORDIC_STAGES(STAGES)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11), .r12(r12),
		.r20(r20), .r21(r21), .r22(r22),
		.out_x(out_x), .out_y(out_y), .out_z(out_z)
	);

	function automatic longint atan_step(int i);
		longint t [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10680862, 5340757, 2670675, 1335343, 667544, 333772,
			166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
			163, 81};
		return t[i];
	endfunction

	function automatic longint clamp_unit(longint v);
		if (v > ONE_Q14)
			return ONE_Q14;
		if (v < -ONE_Q14)
			return -ONE_Q14;
		return v;
	endfunction

	function automatic void cordic_sin_cos(input logic signed [15:0] ang,
			output longint s, output longint c);
		longint a, x, y, z, nx;
		bit flip;
		int n;
		a = ang;
		flip = 0;
		if (a > 16384) begin
			a -= 32768;
			flip = 1;
		end else if (a < -16384) begin
			a += 32768;
			flip = 1;
		end
		x = 652032874;
		y = 0;
		z = a * 65536;
		n = (STAGES > 24) ? 24 : STAGES;
		for (int i = 0; i < n; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_step(i);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_step(i);
			end
			x = nx;
		end
		c = clamp_unit((x + 32768) >>> 16);
		s = clamp_unit((y + 32768) >>> 16);
		if (flip) begin
			c = -c;
			s = -s;
		end
	endfunction

	function automatic logic signed [15:0] round_entry(longint v);
		return 16'(clamp_unit((v + (longint'(1) << 27)) >>> 28));
	endfunction

	function automatic xform_t pose_to_xform(pose_t p);
		xform_t t;
		longint sr, cr, sp, cp, sy, cy;
		cordic_sin_cos(p.roll, sr, cr);
		cordic_sin_cos(p.pitch, sp, cp);
		cordic_sin_cos(p.yaw, sy, cy);
		t.r[0] = round_entry(cy * cp * ONE_Q14);
		t.r[1] = round_entry(cy * sp * sr - sy * cr * ONE_Q14);
		t.r[2] = round_entry(cy * sp * cr + sy * sr * ONE_Q14);
		t.r[3] = round_entry(sy * cp * ONE_Q14);
		t.r[4] = round_entry(sy * sp * sr + cy * cr * ONE_Q14);
		t.r[5] = round_entry(sy * sp * cr - cy * sr * ONE_Q14);
		t.r[6] = 16'(clamp_unit(-sp));
		t.r[7] = round_entry(cp * sr * ONE_Q14);
		t.r[8] = round_entry(cp * cr * ONE_Q14);
		t.tx = p.tx;
		t.ty = p.ty;
		t.tz = p.tz;
		return t;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		errors++;
		$display("mismatch on transform %0d, %s: got %0d, expected %0d",
			xforms_seen, field, got, want);
	endtask

	function automatic logic [15:0] pick_angle();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(16384 + $urandom_range(0, 2) - 1);
			3: return 16'(-16384 + $urandom_range(0, 2) - 1);
			4: return 16'($urandom_range(0, 4) - 2);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_pose(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [15:0] r, logic [15:0] p, logic [15:0] w);
		pose_t q;
		q.tx = x;
		q.ty = y;
		q.tz = z;
		q.roll = r;
		q.pitch = p;
		q.yaw = w;
		pending_poses.insert(pending_poses.size(), q);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		logic [15:0] sweep [10] = '{16'h0000, 16'h8000, 16'h7fff, 16'h4000,
			16'hc000, 16'h4001, 16'hbfff, 16'h2000, 16'h0001, 16'hffff};
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		for (int i = 0; i < 10; i++)
			add_pose(32'h0, 32'hffffffff, 32'h80000000, sweep[i], 16'h0, 16'h0);
		for (int i = 0; i < 10; i++)
			add_pose(32'h7fffffff, 32'h80000000, 32'h1, sweep[i], sweep[(i + 3) % 10],
				sweep[9 - i]);
		add_pose(32'h55555555, 32'haaaaaaaa, 32'hffffffff, 16'h8000, 16'h8000, 16'h8000);
		add_pose(32'haaaaaaaa, 32'h55555555, 32'h0, 16'h7fff, 16'h7fff, 16'h7fff);
		wait (pending_poses.size() == 0 && expected_xforms.size() == 0);
		hold_sender = 1;
		@(posedge clk);
		hold_sender = 0;
		for (int i = 0; i < 1800; i++)
			add_pose($urandom, $urandom, $urandom, pick_angle(), pick_angle(), pick_angle());
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			trans_x <= 0;
			trans_y <= 0;
			trans_z <= 0;
			roll_angle <= 0;
			pitch_angle <= 0;
			yaw_angle <= 0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_valid) begin
				expected_xforms.insert(expected_xforms.size(),
					pose_to_xform(pending_poses.pop_front()));
				poses_sent++;
				send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			end
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 0;
			end else if (pending_poses.size() > 0 && !hold_sender) begin
				in_valid <= 1;
				trans_x <= pending_poses[0].tx;
				trans_y <= pending_poses[0].ty;
				trans_z <= pending_poses[0].tz;
				roll_angle <= pending_poses[0].roll;
				pitch_angle <= pending_poses[0].pitch;
				yaw_angle <= pending_poses[0].yaw;
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		xform_t want;
		logic signed [15:0] got [9];
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
				if (expected_xforms.size() == 0) begin
					report_mismatch("unexpected transform", 1, 0);
				end else begin
					want = expected_xforms.pop_front();
					for (int k = 0; k < 9; k++)
						if (got[k] !== want.r[k])
							report_mismatch($sformatf("r%0d%0d", k / 3, k % 3), got[k], want.r[k]);
					if (out_x !== want.tx)
						report_mismatch("out_x", out_x, want.tx);
					if (out_y !== want.ty)
						report_mismatch("out_y", out_y, want.ty);
					if (out_z !== want.tz)
						report_mismatch("out_z", out_z, want.tz);
				end
				xforms_seen++;
				recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 0;
			end else begin
				out_ready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		wait (poses_sent > 1000);
		wait (pending_poses.size() == 0 && !in_valid && expected_xforms.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("Sent %0d poses, angles swept across the fold edges and pi,", poses_sent);
		$display("and checked %0d transforms with random sender and receiver stalls.",
			xforms_seen);
		if (errors == 0 && expected_xforms.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/ep2t_pkg.sv
rtl/ep2t_cordic_cell.sv
rtl/ep2t_matrix_unit.sv
rtl/euler_pose_to_transform_unit.sv
tb/euler_pose_to_transform_unit_tb.sv
